FILE: rtl/lscf_pkg.sv
// shared types, constants and the colour scaling function of the led strip column framer
// no dependencies
`default_nettype none

package lscf_pkg;

	// column range bound and field widths
	parameter int MAX_WIDTH = 1024;
	parameter int COL_W     = 12;
	parameter int WID_W     = 11;
	parameter int POS_W     = 5;

	localparam logic signed [COL_W-1:0] COL_MAX = COL_W'(MAX_WIDTH);
	localparam logic signed [COL_W-1:0] COL_MIN = -COL_MAX;

	// register indexes
	localparam logic REG_BRIGHTNESS = 1'b0;
	localparam logic REG_WIDTH      = 1'b1;

	// item kinds
	localparam logic ACT_STEP  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// byte positions inside the longest pixel sequence
	localparam logic [POS_W-1:0] POS_START_FIRST = POS_W'(0);
	localparam logic [POS_W-1:0] POS_HEAD        = POS_W'(4);
	localparam logic [POS_W-1:0] POS_BLUE        = POS_W'(5);
	localparam logic [POS_W-1:0] POS_GREEN       = POS_W'(6);
	localparam logic [POS_W-1:0] POS_RED         = POS_W'(7);
	localparam logic [POS_W-1:0] POS_END_LONG    = POS_W'(16);

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	typedef struct packed {
		logic signed [COL_W-1:0] column;
		logic                    show;
		logic                    finished;
	} report_t;

	typedef struct packed {
		logic       is_byte;
		report_t    rpt;
		logic       first;
		logic       last;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} item_t;

	// (c * b) >> 8, or c unchanged when b is zero
	function automatic logic [7:0] scale_colour(input logic [7:0] c, input logic [7:0] b);
		logic [15:0] prod;
		prod = 16'(c) * 16'(b);
		scale_colour = (b == 8'd0) ? c : prod[15:8];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/lscf_column.sv
// step edge tracker: column position, finish flag and column report
// depends on lscf_pkg
`default_nettype none

module lscf_column (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       take,
	input  wire logic                       level,
	input  wire logic                       forward,
	input  wire logic [lscf_pkg::WID_W-1:0] image_width,
	output lscf_pkg::report_t               rpt,
	output logic                            done
);
	import lscf_pkg::*;

	logic                    prev_q;
	logic signed [COL_W-1:0] col_q;
	logic                    done_q;

	logic                    rise;
	logic signed [COL_W-1:0] col_nx;
	logic signed [COL_W-1:0] width_eff;
	logic                    reach;

	always_comb begin
		rise = !prev_q && level && !done_q;
		col_nx = col_q;
		if (forward) begin
			if (col_q < COL_MAX) col_nx = col_q + COL_W'(1);
		end else begin
			if (col_q > COL_MIN) col_nx = col_q - COL_W'(1);
		end
		// widths above the bound act as the bound
		width_eff = ({1'b0, image_width} > COL_MAX) ? COL_MAX : $signed({1'b0, image_width});
		reach = col_nx >= width_eff;
		rpt.column   = rise ? col_nx : col_q;
		rpt.finished = done_q || (rise && reach);
		rpt.show     = rise && !reach && (col_nx >= COL_W'(0));
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			col_q  <= -COL_W'(1);
			done_q <= 1'b0;
		end else if (take) begin
			prev_q <= level;
			col_q  <= rpt.column;
			done_q <= rpt.finished;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lscf_emit.sv
// item register and result sequencer feeding the output register
// depends on lscf_pkg
`default_nettype none

module lscf_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire lscf_pkg::item_t in_item,
	output logic                 in_ready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [23:0]          m_tdata,   // data_byte, column_now, show_column, finished
	output logic                 m_tuser,   // is_byte
	output logic                 m_tlast    // last_byte
);
	import lscf_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic [POS_W-1:0]  pos_q;
	logic              mvalid_q;
	logic [23:0]       mdata_q;
	logic              muser_q;
	logic              mlast_q;

	logic              load_out;
	logic              cur_last;
	logic [7:0]        cur_byte;
	logic [POS_W-1:0]  end_pos;

	always_comb begin
		end_pos = item_s1.last ? POS_END_LONG : POS_RED;
		cur_last = !item_s1.is_byte || (pos_q == end_pos);
		case (pos_q) inside
			[POS_START_FIRST:POS_W'(3)]: cur_byte = BYTE_ZERO;
			POS_BLUE:                    cur_byte = item_s1.blue;
			POS_GREEN:                   cur_byte = item_s1.green;
			POS_RED:                     cur_byte = item_s1.red;
			default:                     cur_byte = BYTE_ONES;
		endcase
	end

	assign load_out = valid_s1 && (!mvalid_q || m_tready);
	assign in_ready = !valid_s1 || (load_out && cur_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (load_out) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
			pos_q   <= in_item.first ? POS_START_FIRST : POS_HEAD;
		end else if (load_out && !cur_last) begin
			pos_q <= pos_q + POS_W'(1);
		end
		if (load_out) begin
			muser_q <= item_s1.is_byte;
			mlast_q <= cur_last;
			if (item_s1.is_byte)
				mdata_q <= {16'd0, cur_byte};
			else
				mdata_q <= {2'b00, item_s1.rpt.finished, item_s1.rpt.show,
					item_s1.rpt.column, BYTE_ZERO};
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;
	assign m_tlast  = mlast_q;

endmodule

`default_nettype wire

FILE: rtl/led_strip_column_framer_top.sv
// top level of the led strip column framer: config registers, input decode, column tracker, emitter
// depends on lscf_pkg, lscf_column, lscf_emit
`default_nettype none

// Takes step-pin samples and pixels on one stream and returns column reports and
// serial strip bytes on another. A step sample gives one report, and samples can
// follow each other every cycle while the output is not stalled. A pixel gives four
// bytes (0xFF, blue, green, red), plus four leading zero bytes when it opens a column
// and nine 0xFF bytes when it closes one: the output register sends one transfer per
// cycle unless m_tready holds it, and the item register waits until its last result
// has moved out. The next item is taken in the cycle its predecessor's last result
// loads the output register. Once the image is finished, pixels are consumed with
// no result. Colours are scaled as (c*brightness)>>8 when the item is taken;
// brightness zero passes colours unchanged.
module led_strip_column_framer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // step_level, step_forward, red, green, blue, first_pixel
	input  wire logic        s_tuser,   // action
	input  wire logic        s_tlast,   // last_pixel
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // data_byte, column_now, show_column, finished
	output logic             m_tuser,   // is_byte
	output logic             m_tlast    // last_byte
);
	import lscf_pkg::*;

	logic [7:0]       bright_q;
	logic [WID_W-1:0] width_q;

	logic             cfg_wr;
	logic             in_take;
	logic             step_take;
	logic             keep;
	logic             done;
	logic             emit_ready;
	report_t          rpt;
	item_t            item;

	// register write on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= 8'd60;
			width_q  <= WID_W'(MAX_WIDTH);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_BRIGHTNESS: bright_q <= pwdata[7:0];
				REG_WIDTH:      width_q  <= pwdata[WID_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BRIGHTNESS: prdata = {24'd0, bright_q};
			REG_WIDTH:      prdata = {{(32-WID_W){1'b0}}, width_q};
			default:        prdata = 32'd0;
		endcase
	end

	// input transfer and split by kind
	assign s_tready  = emit_ready;
	assign in_take   = s_tvalid && s_tready;
	assign step_take = in_take && (s_tuser == ACT_STEP);
	// pixels after the finish produce nothing and are not stored
	assign keep      = (s_tuser == ACT_STEP) || !done;

	lscf_column u_column (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (step_take),
		.level       (s_tdata[0]),
		.forward     (s_tdata[1]),
		.image_width (width_q),
		.rpt         (rpt),
		.done        (done)
	);

	always_comb begin
		item.is_byte = (s_tuser == ACT_PIXEL);
		item.rpt     = rpt;
		item.first   = s_tdata[26];
		item.last    = s_tlast;
		item.red     = scale_colour(s_tdata[9:2], bright_q);
		item.green   = scale_colour(s_tdata[17:10], bright_q);
		item.blue    = scale_colour(s_tdata[25:18], bright_q);
	end

	lscf_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid && keep),
		.in_item  (item),
		.in_ready (emit_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

FILE: test/lscf_result_checker.sv
// result checker for the led strip column framer: tracks register writes, predicts every
// column report and strip byte from accepted input transfers and compares result transfers
// depends on lscf_pkg
module lscf_result_checker
	import lscf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        m_tlast,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic                    is_byte;
		logic [7:0]              data;
		logic                    last;
		logic signed [COL_W-1:0] column;
		logic                    show;
		logic                    finished;
	} strip_result_t;

	strip_result_t expected_strip_q [$];

	// shadow of the block's registers and column state
	logic [7:0]              brightness_reg;
	logic [WID_W-1:0]        width_reg;
	logic                    prev_level;
	logic signed [COL_W-1:0] column;
	logic                    painting_done;

	function automatic logic [7:0] dimmed(input logic [7:0] c);
		logic [15:0] prod;
		prod = 16'(c) * 16'(brightness_reg);
		return (brightness_reg == 8'd0) ? c : prod[15:8];
	endfunction

	task automatic push_result(input logic is_byte, input logic [7:0] data, input logic last,
			input logic signed [COL_W-1:0] col, input logic show, input logic fin);
		strip_result_t r;
		r.is_byte  = is_byte;
		r.data     = data;
		r.last     = last;
		r.column   = col;
		r.show     = show;
		r.finished = fin;
		expected_strip_q.push_back(r);
	endtask

	task automatic predict_strip_output(input logic action, input logic [31:0] d,
			input logic close_frame);
		logic       level;
		logic       fwd;
		logic       show;
		int         eff_width;
		logic [7:0] seq [$];
		level = d[0];
		fwd   = d[1];
		if (action == ACT_STEP) begin
			eff_width = (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
			show = 1'b0;
			if (!prev_level && level && !painting_done) begin
				if (fwd) begin
					if (column < COL_MAX)
						column = column + COL_W'(1);
				end else if (column > COL_MIN) begin
					column = column - COL_W'(1);
				end
				if (int'(column) >= eff_width)
					painting_done = 1'b1;
				else if (column >= 0)
					show = 1'b1;
			end
			prev_level = level;
			push_result(1'b0, 8'd0, 1'b1, column, show, painting_done);
		end else if (!painting_done) begin
			if (d[26])
				repeat (4) seq.push_back(BYTE_ZERO);
			seq.push_back(BYTE_ONES);
			seq.push_back(dimmed(d[25:18]));
			seq.push_back(dimmed(d[17:10]));
			seq.push_back(dimmed(d[9:2]));
			if (close_frame)
				repeat (9) seq.push_back(BYTE_ONES);
			foreach (seq[i])
				push_result(1'b1, seq[i], i == seq.size() - 1, '0, 1'b0, 1'b0);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		strip_result_t want;
		if (!arst_n) begin
			brightness_reg = 8'd60;
			width_reg      = WID_W'(1024);
			prev_level     = 1'b0;
			column         = -1;
			painting_done  = 1'b0;
			expected_strip_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_BRIGHTNESS)
					brightness_reg = pwdata[7:0];
				else
					width_reg = pwdata[WID_W-1:0];
			end
			if (s_tvalid && s_tready)
				predict_strip_output(s_tuser, s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_strip_q.size() == 0) begin
					$error("unexpected result transfer: tdata %06h tuser %0b tlast %0b",
						m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					want = expected_strip_q.pop_front();
					check_field("is_byte", want.is_byte, m_tuser);
					check_field("data_byte", want.data, m_tdata[7:0]);
					check_field("last_byte", want.last, m_tlast);
					check_field("column_now", int'(want.column), int'($signed(m_tdata[19:8])));
					check_field("show_column", want.show, m_tdata[20]);
					check_field("finished", want.finished, m_tdata[21]);
				end
			end
			pending = expected_strip_q.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// testbench top for led_strip_column_framer_top: clock, reset, register writes, stimulus
// and idling on both streams, watchdog and verdict; checking is done by lscf_result_checker
// depends on lscf_pkg, led_strip_column_framer_top, lscf_result_checker
module tb_top;
	import lscf_pkg::*;

	// cycles without any transfer before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	// room for the longest pixel sequence to move out, with some margin
	localparam int SETTLE_CYCLES  = 24;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // step_level, step_forward, red, green, blue, first_pixel
	logic        s_tuser  = 1'b0; // action
	logic        s_tlast  = 1'b0; // last_pixel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // data_byte, column_now, show_column, finished
	logic        m_tuser;         // is_byte
	logic        m_tlast;         // last_byte

	int fail_count;
	int pending;
	int stall_left = 0;
	int idle_cycles = 0;
	// when set, neither side idles (back-to-back stretches)
	bit quiet = 1'b1;

	led_strip_column_framer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lscf_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// colours biased toward the extremes
	function automatic logic [7:0] pick_colour();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// result side: random stalls on m_tready, one assignment per falling edge
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < 25) begin
			stall_left <= idle_len() - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: counts cycles in which neither stream moves a transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("led_strip_column_framer_top regression: fail");
			$finish;
		end
	end

	// one input transfer; valid stays high into the next item when no gap is drawn
	task automatic send_item(input logic action, input logic level, input logic fwd,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
			input logic first, input logic last);
		int gap;
		gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= action;
		s_tlast  <= last;
		s_tdata  <= {5'b0, first, blue, green, red, fwd, level};
		do @(posedge clk); while (!s_tready);
	endtask

	// unused fields of each kind carry random values so every bit toggles
	task automatic send_step(input logic level, input logic fwd);
		send_item(ACT_STEP, level, fwd, 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom), 1'($urandom));
	endtask

	task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
			input logic [7:0] blue, input logic first, input logic last);
		send_item(ACT_PIXEL, 1'($urandom), 1'($urandom), red, green, blue, first, last);
	endtask

	// drop valid, wait until every predicted result has arrived, then let the block settle
	// (a pixel after the image is finished is consumed without any result)
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// setup cycle, then access cycle; the write lands when pready is seen high
	task automatic write_reg(input logic index, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly well-formed column frames and step pulses, the rest random noise
	task automatic mixed_traffic(input int count);
		int   sent;
		int   pick;
		int   frame_len;
		logic fwd;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16)
					: $urandom_range(1, 5);
				for (int k = 0; k < frame_len; k++)
					send_pixel(pick_colour(), pick_colour(), pick_colour(),
						k == 0, k == frame_len - 1);
				sent += frame_len;
			end else if (pick < 85) begin
				fwd = 1'($urandom);
				send_step(1'b0, fwd);
				send_step(1'b1, fwd);
				sent += 2;
			end else begin
				send_item(1'($urandom), 1'($urandom), 1'($urandom), pick_colour(),
					pick_colour(), pick_colour(), 1'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		// reset held low at the start, then released on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part on reset register values (brightness 60, width 1024)
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);   // single-pixel frame, full white
		send_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);   // frame opens, black
		send_pixel(8'hFF, 8'h00, 8'h80, 1'b0, 1'b0);   // middle pixel
		send_pixel(8'h01, 8'h02, 8'h03, 1'b0, 1'b1);   // frame closes
		send_step(1'b1, 1'b1);                         // rising edge forward: column 0 shown
		send_step(1'b1, 1'b1);                         // level held high: no move
		send_step(1'b0, 1'b0);                         // falling edge: no move
		send_step(1'b1, 1'b0);                         // rising edge back to -1
		send_step(1'b0, 1'b0);
		send_step(1'b1, 1'b0);                         // negative column, not shown
		send_pixel(8'h55, 8'hAA, 8'h7F, 1'b1, 1'b1);   // pixels still encoded at a negative column
		send_step(1'b0, 1'b1);
		send_step(1'b1, 1'b1);
		send_step(1'b0, 1'b1);
		send_step(1'b1, 1'b1);
		send_step(1'b0, 1'b1);
		send_step(1'b1, 1'b1);                         // back inside the image at column 1
		send_pixel(8'h80, 8'h80, 8'h80, 1'b1, 1'b1);

		// hold the sender until every expected result is back
		drain();

		// full brightness, width at its nominal bound, with idling on both sides
		write_reg(REG_BRIGHTNESS, 32'd255);
		write_reg(REG_WIDTH, 32'd1024);
		quiet = 1'b0;
		mixed_traffic(45);
		drain();

		// brightness zero passes colours through; width above the bound acts as the bound
		write_reg(REG_BRIGHTNESS, 32'd0);
		write_reg(REG_WIDTH, 32'd2047);
		mixed_traffic(45);
		drain();

		// walk the column back a few columns, back to back
		write_reg(REG_BRIGHTNESS, 32'd1);
		write_reg(REG_WIDTH, 32'd1024);
		quiet = 1'b1;
		for (int k = 0; k < 5; k++) begin
			send_step(1'b0, 1'b0);
			send_step(1'b1, 1'b0);
		end
		quiet = 1'b0;
		mixed_traffic(20);
		drain();

		// smallest width: climb forward until the image finishes, then keep stepping
		write_reg(REG_BRIGHTNESS, 32'($urandom_range(2, 254)));
		write_reg(REG_WIDTH, 32'd1);
		for (int k = 0; k < 25; k++) begin
			send_step(1'b0, 1'b1);
			send_step(1'b1, 1'b1);
		end

		// after the finish: pixels are swallowed, steps still report
		mixed_traffic(25);
		drain();
		write_reg(REG_BRIGHTNESS, 32'd128);
		write_reg(REG_WIDTH, 32'd512);
		mixed_traffic(15);

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("led_strip_column_framer_top regression: pass");
		end else begin
			$display("led_strip_column_framer_top regression: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/lscf_pkg.sv
rtl/lscf_column.sv
rtl/lscf_emit.sv
rtl/led_strip_column_framer_top.sv
test/lscf_result_checker.sv
test/tb_top.sv
